// File: sv/cch_pkg.sv
// Shared types and constants for the color channel histogram.
// No dependencies; imported by cch_result_fifo and color_channel_histogram.
package cch_pkg;

  // Fixed widths of the transaction fields and registers.
  localparam int SAMPLE_W  = 13;
  localparam int MEAN_W    = 8;
  localparam int NORM_W    = 24;
  localparam int OUT_CNT_W = 18;
  localparam int CH_W      = 2;
  localparam int BIN_IDX_W = 8;

  // APB register port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Register reset values.
  localparam logic [MEAN_W-1:0] MEAN_BLUE_RST  = 8'd104;
  localparam logic [MEAN_W-1:0] MEAN_GREEN_RST = 8'd117;
  localparam logic [MEAN_W-1:0] MEAN_RED_RST   = 8'd123;
  localparam logic [NORM_W-1:0] NORM_MULT_RST  = 24'd29127;

  // Register indexes (byte address is four times the index).
  typedef enum logic [1:0] {
    REG_MEAN_BLUE  = 2'd0,
    REG_MEAN_GREEN = 2'd1,
    REG_MEAN_RED   = 2'd2,
    REG_NORM_MULT  = 2'd3
  } reg_idx_e;

  // Input transaction modes.
  typedef enum logic {
    MODE_ACCUM = 1'b0,
    MODE_READ  = 1'b1
  } mode_e;

  // One result transaction.
  typedef struct packed {
    logic [OUT_CNT_W-1:0] bin_count;
    logic [NORM_W-1:0]    normalized;
    logic                 clip_flag;
  } result_t;

endpackage

// File: sv/color_channel_histogram.sv
// Color channel histogram: per-channel bin store with accumulate and read-and-clear.
// Depends on cch_pkg and instantiates cch_result_fifo.
//
// The block counts samples into CHANNELS x BINS_PER_CHANNEL bins held in one
// single-port-write, registered-read memory. After reset it runs a clearing
// pass that zeroes every bin and accepts no transaction until it ends;
// register writes are taken throughout. After that it accepts one input
// transaction per clock: the bin address is formed at the input, the memory
// is read at acceptance, and the next cycle updates the bin, forwarding the
// value written in the previous cycle when two transactions in a row hit the
// same bin. A read-and-clear transaction passes through the stage 1 and
// stage 2 registers into the result FIFO; its count is multiplied by
// norm_multiplier after stage 2. Up to four results may wait for the output;
// the input stalls only when that many are outstanding.
module color_channel_histogram #(
  parameter int BINS_PER_CHANNEL = 256,
  parameter int CHANNELS         = 3,
  parameter int COUNT_WIDTH      = 18,
  parameter int FRAC_BITS        = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // APB register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cch_pkg::APB_AW-1:0]           paddr,
  input  logic [cch_pkg::APB_DW-1:0]           pwdata,
  output logic [cch_pkg::APB_DW-1:0]           prdata,
  output logic                                 pready,
  // Input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 mode_i,
  input  logic [cch_pkg::CH_W-1:0]             channel_i,
  input  logic signed [cch_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [cch_pkg::BIN_IDX_W-1:0]        bin_index_i,
  // Output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [cch_pkg::OUT_CNT_W-1:0]        bin_count_o,
  output logic [cch_pkg::NORM_W-1:0]           normalized_o,
  output logic                                 clip_flag_o
);
  import cch_pkg::*;

  localparam int TOTAL_BINS = CHANNELS * BINS_PER_CHANNEL;
  localparam int AW         = $clog2(TOTAL_BINS);
  localparam int IDX_W      = $clog2(BINS_PER_CHANNEL);
  localparam int W_A        = (MEAN_W + FRAC_BITS > SAMPLE_W) ? MEAN_W + FRAC_BITS : SAMPLE_W;
  localparam int W_B        = (W_A > IDX_W + 1) ? W_A : IDX_W + 1;
  localparam int SUM_W      = W_B + 2;
  localparam int PROD_W     = COUNT_WIDTH + NORM_W;
  localparam int OUT_DEPTH  = 4;
  localparam int PEND_W     = $clog2(OUT_DEPTH + 1);

  localparam logic [AW-1:0]           BINS_A    = AW'(BINS_PER_CHANNEL);
  localparam logic [AW-1:0]           LAST_ADDR = AW'(TOTAL_BINS - 1);
  localparam logic [COUNT_WIDTH-1:0]  CNT_MAX   = '1;
  localparam logic signed [SUM_W-1:0] NEG_LIM   = -(SUM_W'(2 ** FRAC_BITS));
  localparam logic signed [SUM_W-1:0] IDX_MAX   = SUM_W'(BINS_PER_CHANNEL - 1);
  localparam logic [PEND_W-1:0]       PEND_MAX  = PEND_W'(OUT_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MEAN_W-1:0] mean_blue_q, mean_green_q, mean_red_q;
  logic [NORM_W-1:0] norm_mult_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_blue_q  <= MEAN_BLUE_RST;
      mean_green_q <= MEAN_GREEN_RST;
      mean_red_q   <= MEAN_RED_RST;
      norm_mult_q  <= NORM_MULT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MEAN_BLUE:  mean_blue_q  <= pwdata[MEAN_W-1:0];
        REG_MEAN_GREEN: mean_green_q <= pwdata[MEAN_W-1:0];
        REG_MEAN_RED:   mean_red_q   <= pwdata[MEAN_W-1:0];
        REG_NORM_MULT:  norm_mult_q  <= pwdata[NORM_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (cfg_idx)
      REG_MEAN_BLUE:  prdata = APB_DW'(mean_blue_q);
      REG_MEAN_GREEN: prdata = APB_DW'(mean_green_q);
      REG_MEAN_RED:   prdata = APB_DW'(mean_red_q);
      REG_NORM_MULT:  prdata = APB_DW'(norm_mult_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------------------
  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == LAST_ADDR) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: bin address and clip detection
  // ---------------------------------------------------------------------------
  logic [PEND_W-1:0]       pend_q;
  logic                    in_acc;
  logic                    ch_ok;
  logic                    bin_ok;
  logic                    item_ok;
  logic [MEAN_W-1:0]       mean_sel;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_sh;
  logic [IDX_W-1:0]        acc_idx;
  logic [IDX_W-1:0]        rd_idx;
  logic [IDX_W-1:0]        sel_idx;
  logic                    clip_evt;
  logic [AW-1:0]           in_addr;
  logic [31:0]             bin_ext;

  assign in_ready_o = !clearing_q && (pend_q < PEND_MAX);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    case (channel_i)
      2'd0:    mean_sel = mean_blue_q;
      2'd1:    mean_sel = mean_green_q;
      2'd2:    mean_sel = mean_red_q;
      default: mean_sel = '0;
    endcase
  end

  // Add the mean back, truncate toward zero and clamp to the channel's bins.
  always_comb begin
    sum      = SUM_W'(sample_i) + (signed'(SUM_W'(mean_sel)) <<< FRAC_BITS);
    sum_sh   = sum >>> FRAC_BITS;
    acc_idx  = sum_sh[IDX_W-1:0];
    clip_evt = 1'b0;
    if (sum < 0) begin
      acc_idx  = '0;
      clip_evt = (sum <= NEG_LIM);
    end else if (sum_sh > IDX_MAX) begin
      acc_idx  = IDX_W'(BINS_PER_CHANNEL - 1);
      clip_evt = 1'b1;
    end
  end

  assign bin_ext = 32'(bin_index_i);
  assign rd_idx  = bin_ext[IDX_W-1:0];
  assign ch_ok   = ({1'b0, channel_i} < 3'(CHANNELS));
  assign bin_ok  = (bin_ext < 32'(BINS_PER_CHANNEL));
  assign item_ok = (mode_i == MODE_READ) ? (ch_ok && bin_ok) : ch_ok;
  assign sel_idx = (mode_i == MODE_READ) ? rd_idx : acc_idx;
  assign in_addr = item_ok ? (AW'(channel_i) * BINS_A + AW'(sel_idx)) : '0;

  // Sticky clip flag.
  logic clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
    end else if (in_acc && (mode_i == MODE_ACCUM) && ch_ok && clip_evt) begin
      clip_q <= 1'b1;
    end
  end

  // Stage 1 control registers.
  logic          s1_valid_q;
  mode_e         s1_mode_q;
  logic          s1_ok_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q <= mode_e'(mode_i);
      s1_ok_q   <= item_ok;
      s1_addr_q <= in_addr;
      s1_clip_q <= clip_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Bin memory with one write port and one registered read port
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] mem_q [TOTAL_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic                   s1_we;
  logic [COUNT_WIDTH-1:0] s1_wdata;

  assign mem_we    = clearing_q || s1_we;
  assign mem_waddr = clearing_q ? clr_addr_q : s1_addr_q;
  assign mem_wdata = clearing_q ? '0 : s1_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[in_addr];
  end

  // Last update, for forwarding into a back-to-back transaction on the same bin.
  logic                   fw_valid_q;
  logic [AW-1:0]          fw_addr_q;
  logic [COUNT_WIDTH-1:0] fw_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_valid_q <= 1'b0;
    end else begin
      fw_valid_q <= s1_we && !clearing_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fw_addr_q <= s1_addr_q;
    fw_data_q <= s1_wdata;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: bin update
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] cur_count;
  logic [COUNT_WIDTH-1:0] s1_count;
  logic                   s1_is_read;

  assign cur_count  = (fw_valid_q && (fw_addr_q == s1_addr_q)) ? fw_data_q : rd_data_q;
  assign s1_is_read = s1_valid_q && (s1_mode_q == MODE_READ);

  always_comb begin
    s1_we    = 1'b0;
    s1_wdata = '0;
    s1_count = '0;
    if (s1_valid_q && s1_ok_q) begin
      s1_we = 1'b1;
      if (s1_mode_q == MODE_READ) begin
        s1_count = cur_count;
      end else begin
        s1_wdata = (cur_count == CNT_MAX) ? cur_count : cur_count + 1'b1;
      end
    end
  end

  // Stage 2 registers: read results only.
  logic                   s2_valid_q;
  logic [COUNT_WIDTH-1:0] s2_count_q;
  logic                   s2_clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_is_read) begin
      s2_count_q <= s1_count;
      s2_clip_q  <= s1_clip_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: normalize and saturate to Q0.24
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] prod;
  logic [63:0]       prod_ext;
  logic [63:0]       count_ext;
  result_t           res;

  assign prod      = PROD_W'(s2_count_q) * PROD_W'(norm_mult_q);
  assign prod_ext  = 64'(prod);
  assign count_ext = 64'(s2_count_q);

  always_comb begin
    res.bin_count  = count_ext[OUT_CNT_W-1:0];
    res.normalized = (|prod_ext[63:32]) ? '1 : prod_ext[31:8];
    res.clip_flag  = s2_clip_q;
  end

  // ---------------------------------------------------------------------------
  // Output queue and outstanding-result count
  // ---------------------------------------------------------------------------
  result_t out_data;
  logic    out_acc;

  cch_result_fifo #(
    .DEPTH(OUT_DEPTH)
  ) u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_valid_q),
    .push_data_i (res),
    .pop_i       (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (out_data)
  );

  assign bin_count_o  = out_data.bin_count;
  assign normalized_o = out_data.normalized;
  assign clip_flag_o  = out_data.clip_flag;
  assign out_acc      = out_valid_o && out_ready_i;

  logic pend_inc;

  assign pend_inc = in_acc && (mode_i == MODE_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (pend_inc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (!pend_inc && out_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PEND_MAX)
    else $error("outstanding result count exceeds output queue depth");

  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !in_ready_o)
    else $error("transaction accepted during clearing pass");

  a_out_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != '0))
    else $error("result presented with no outstanding read transaction");

  a_read_reaches_stage2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_inc |=> ##1 s2_valid_q)
    else $error("read transaction did not reach normalization stage");

endmodule

// File: sv/cch_result_fifo.sv
// Small register FIFO that holds finished result transactions for the output.
// Depends on cch_pkg for the result_t type.
module cch_result_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cch_pkg::result_t push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output cch_pkg::result_t data_o
);
  import cch_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  result_t            slots_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots carry no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // A push lands on a full FIFO only together with a pop.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CNT_W'(DEPTH)) |-> (!push_i || do_pop))
    else $error("result FIFO pushed while full");

  // The fill count advances on a push without a pop.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("result FIFO count did not advance on push");

  // Output data holds while a transaction waits.
  a_head_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !pop_i) |=> $stable(data_o))
    else $error("result FIFO head changed while stalled");

endmodule
